FILE: hdl/rpcg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the rainbow palette color generator
// no dependencies; imported by every module of the block

package rpcg_pkg;

  localparam int COL_W       = 12;
  localparam int ROW_W       = 12;
  localparam int GRID_W      = 13;
  localparam int CHAN_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  // long division chain: dividend bits, divisor bits, lanes, sideband bits
  localparam int DIV_W  = 30;
  localparam int DEN_W  = 13;
  localparam int LANES  = 4;
  localparam int SIDE_W = 32;

  // registers from accept to result strobe
  localparam int PIPE_LAT = 2 * DIV_W + 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1,
    CFG_MAX_LEVEL    = 2'd2,
    CFG_GRAY_STRIP   = 2'd3
  } cfg_idx_e;

  // one lane of a restoring divider: partial remainder, dividend/quotient, divisor
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_lane_t;

endpackage

FILE: hdl/rainbow_palette_color_generator_core.sv
`timescale 1ns / 1ps
// top level of the rainbow palette color generator
// depends on rpcg_pkg and rpcg_div_chain

// A request (column, row) is taken on every clock where start is high; busy is
// always low, so one color per clock is sustained. Each result is on the ports for
// one cycle, with result_valid_o high: there is no way to hold it off. It passes through
// two 30-cell long-division chains in series (hue ramp by the column count, then row
// blend by half the color rows) plus five plain pipeline registers. Results come out
// in request order. Configuration must be written only while no request is in flight;
// the pipeline reads the registers live.

module rainbow_palette_color_generator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [rpcg_pkg::COL_W-1:0]          column_i,
  input  logic [rpcg_pkg::ROW_W-1:0]          row_i,
  input  logic                                cfg_we_i,
  input  logic [rpcg_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [rpcg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [rpcg_pkg::CHAN_W-1:0]         red_o,
  output logic [rpcg_pkg::CHAN_W-1:0]         green_o,
  output logic [rpcg_pkg::CHAN_W-1:0]         blue_o,
  output logic                                invalid_o
);
  import rpcg_pkg::*;

  // sideband through the hue divider
  typedef struct packed {
    logic [1:0]       pad;
    logic             bad;
    logic             gray;
    logic [2:0]       seg;
    logic             s_neg;
    logic [ROW_W-1:0] y;
    logic [COL_W-1:0] x;
  } side_a_t;

  // sideband through the blend divider
  typedef struct packed {
    logic [25:0] pad;
    logic        bad;
    logic        gray;
    logic        lo;
    logic [2:0]  sgn;
  } side_b_t;

  // configuration registers
  logic [GRID_W-1:0] grid_columns_q;
  logic [GRID_W-1:0] grid_rows_q;
  logic [CHAN_W-1:0] max_level_q;
  logic              gray_strip_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q  <= GRID_W'(16);
      grid_rows_q     <= GRID_W'(16);
      max_level_q     <= CHAN_W'(255);
      gray_strip_on_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GRID_COLUMNS: grid_columns_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_ROWS:    grid_rows_q     <= cfg_wdata_i[GRID_W-1:0];
        CFG_MAX_LEVEL:    max_level_q     <= cfg_wdata_i[CHAN_W-1:0];
        CFG_GRAY_STRIP:   gray_strip_on_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // derived settings
  logic signed [14:0] n_s;
  logic [GRID_W-1:0]  n_u;
  logic [GRID_W-1:0]  n1;
  logic [ROW_W-1:0]   half;
  logic [ROW_W-1:0]   n1_half;
  logic [GRID_W-1:0]  w_m1;
  logic [DEN_W-1:0]   gray_den;
  logic               cfg_bad;

  always_comb begin
    n_s      = $signed({2'b00, grid_rows_q}) - $signed({14'd0, gray_strip_on_q});
    n_u      = n_s[GRID_W-1:0];
    n1       = n_u - GRID_W'(1);
    half     = n_u[GRID_W-1:1];
    n1_half  = n1[GRID_W-1:1];
    w_m1     = grid_columns_q - GRID_W'(1);
    gray_den = {w_m1[GRID_W-2:0], 1'b0};
    cfg_bad  = (grid_columns_q < GRID_W'(2)) || (grid_columns_q > GRID_W'(MAX_COLUMNS)) ||
               (grid_rows_q > GRID_W'(MAX_ROWS)) || (n_s < 15'sd2);
  end

  // stage 1: segment pick, offset in segment, range checks
  logic [16:0]        x6, x6p, kw1, kw2, kw3, kw4, kw5, kw_sel;
  logic [2:0]         seg_d;
  logic signed [17:0] s_d, s_n;
  logic               bad_d, gray_d;

  always_comb begin
    x6  = ({5'd0, column_i} << 2) + ({5'd0, column_i} << 1);
    x6p = x6 + 17'd6;
    kw1 = {4'd0, grid_columns_q};
    kw2 = kw1 << 1;
    kw3 = kw1 + kw2;
    kw4 = kw1 << 2;
    kw5 = kw4 + kw1;
    // x < k*w/6 with truncating division is the same as 6x+6 <= k*w
    if (x6p <= kw1) begin
      seg_d = 3'd0; kw_sel = '0;
    end else if (x6p <= kw2) begin
      seg_d = 3'd1; kw_sel = kw1;
    end else if (x6p <= kw3) begin
      seg_d = 3'd2; kw_sel = kw2;
    end else if (x6p <= kw4) begin
      seg_d = 3'd3; kw_sel = kw3;
    end else if (x6p <= kw5) begin
      seg_d = 3'd4; kw_sel = kw4;
    end else begin
      seg_d = 3'd5; kw_sel = kw5;
    end
    s_d    = $signed({1'b0, x6}) - $signed({1'b0, kw_sel});
    s_n    = -s_d;
    bad_d  = cfg_bad || ({1'b0, column_i} >= grid_columns_q) ||
             ({1'b0, row_i} >= grid_rows_q);
    gray_d = gray_strip_on_q && ({1'b0, row_i} == n_u);
  end

  logic              s1_valid_q;
  logic              s1_bad_q, s1_gray_q, s1_neg_q;
  logic [2:0]        s1_seg_q;
  logic [11:0]       s1_sabs_q;
  logic [COL_W-1:0]  s1_x_q;
  logic [ROW_W-1:0]  s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_q  <= bad_d;
    s1_gray_q <= gray_d;
    s1_neg_q  <= s_d[17];
    s1_seg_q  <= seg_d;
    s1_sabs_q <= s_d[17] ? s_n[11:0] : s_d[11:0];
    s1_x_q    <= column_i;
    s1_y_q    <= row_i;
  end

  // stage 2: hue numerator max_level * |s|
  logic                        s2_valid_q;
  div_lane_t [LANES-1:0]       s2_lane_q;
  side_a_t                     s2_side_q;
  logic [DIV_W-1:0]            hue_num;

  assign hue_num = {14'd0, max_level_q} * {18'd0, s1_sabs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_lane_q[0].rem   <= '0;
    s2_lane_q[0].num   <= hue_num;
    s2_lane_q[0].den   <= grid_columns_q;
    for (int l = 1; l < LANES; l++) begin
      s2_lane_q[l] <= '0;
    end
    s2_side_q.pad      <= '0;
    s2_side_q.bad      <= s1_bad_q;
    s2_side_q.gray     <= s1_gray_q;
    s2_side_q.seg      <= s1_seg_q;
    s2_side_q.s_neg    <= s1_neg_q;
    s2_side_q.y        <= s1_y_q;
    s2_side_q.x        <= s1_x_q;
  end

  // hue divider
  logic                  da_valid;
  div_lane_t [LANES-1:0] da_lanes;
  logic [SIDE_W-1:0]     da_side_w;
  side_a_t               da_side;

  rpcg_div_chain u_div_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .lanes_i (s2_lane_q),
    .side_i  (SIDE_W'(s2_side_q)),
    .valid_o (da_valid),
    .lanes_o (da_lanes),
    .side_o  (da_side_w)
  );

  assign da_side = side_a_t'(da_side_w);

  // stage 3: channel levels before the row blend, may overshoot or dip below zero
  logic signed [18:0] hq, hq_mag, mx19, m_minus;
  logic signed [18:0] c_d [3];

  always_comb begin
    hq_mag  = $signed({1'b0, da_lanes[0].num[17:0]});
    hq      = da_side.s_neg ? -hq_mag : hq_mag;
    mx19    = $signed({3'b000, max_level_q});
    m_minus = mx19 - hq;
    unique case (da_side.seg)
      3'd0:    begin c_d[0] = mx19;    c_d[1] = hq;      c_d[2] = '0;      end
      3'd1:    begin c_d[0] = m_minus; c_d[1] = mx19;    c_d[2] = '0;      end
      3'd2:    begin c_d[0] = '0;      c_d[1] = mx19;    c_d[2] = hq;      end
      3'd3:    begin c_d[0] = '0;      c_d[1] = m_minus; c_d[2] = mx19;    end
      3'd4:    begin c_d[0] = hq;      c_d[1] = '0;      c_d[2] = mx19;    end
      default: begin c_d[0] = mx19;    c_d[1] = '0;      c_d[2] = m_minus; end
    endcase
  end

  logic               s3_valid_q;
  logic signed [18:0] s3_c_q [3];
  logic               s3_bad_q, s3_gray_q;
  logic [COL_W-1:0]   s3_x_q;
  logic [ROW_W-1:0]   s3_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= da_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_c_q    <= c_d;
    s3_bad_q  <= da_side.bad;
    s3_gray_q <= da_side.gray;
    s3_x_q    <= da_side.x;
    s3_y_q    <= da_side.y;
  end

  // stage 4: blend numerators, or the gray ramp numerator on the gray row
  logic               lo;
  logic [ROW_W-1:0]   fac;
  logic [GRID_W-1:0]  down;
  logic signed [18:0] c_n [3];
  logic [17:0]        c_abs [3];
  logic [2:0]         c_sgn;
  logic [ROW_W-1:0]   up;
  logic [DIV_W-1:0]   c_num [3];
  logic [DIV_W-1:0]   up_num, gray_num, lane0_num;
  logic [DEN_W-1:0]   lane0_den;

  always_comb begin
    lo   = (s3_y_q < half);
    down = n1 - {1'b0, s3_y_q};
    fac  = lo ? s3_y_q : down[ROW_W-1:0];
    up   = s3_y_q - n1_half;
    for (int i = 0; i < 3; i++) begin
      c_n[i]   = -s3_c_q[i];
      c_sgn[i] = s3_c_q[i][18];
      c_abs[i] = c_sgn[i] ? c_n[i][17:0] : s3_c_q[i][17:0];
      c_num[i] = {12'd0, c_abs[i]} * {18'd0, fac};
    end
    up_num    = lo ? '0 : ({14'd0, max_level_q} * {18'd0, up});
    // 2*M*x + (w-1), rounded to nearest by the divide by 2*(w-1)
    gray_num  = (({14'd0, max_level_q} * {18'd0, s3_x_q}) << 1) + {17'd0, w_m1};
    lane0_num = s3_gray_q ? gray_num : c_num[0];
    lane0_den = s3_gray_q ? gray_den : {1'b0, half};
  end

  logic                  s4_valid_q;
  div_lane_t [LANES-1:0] s4_lane_q;
  side_b_t               s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_lane_q[0].rem <= '0;
    s4_lane_q[0].num <= lane0_num;
    s4_lane_q[0].den <= lane0_den;
    for (int i = 1; i < 3; i++) begin
      s4_lane_q[i].rem <= '0;
      s4_lane_q[i].num <= c_num[i];
      s4_lane_q[i].den <= {1'b0, half};
    end
    s4_lane_q[3].rem <= '0;
    s4_lane_q[3].num <= up_num;
    s4_lane_q[3].den <= {1'b0, half};
    s4_side_q.pad    <= '0;
    s4_side_q.bad    <= s3_bad_q;
    s4_side_q.gray   <= s3_gray_q;
    s4_side_q.lo     <= lo;
    s4_side_q.sgn    <= c_sgn;
  end

  // blend divider
  logic                  db_valid;
  div_lane_t [LANES-1:0] db_lanes;
  logic [SIDE_W-1:0]     db_side_w;
  side_b_t               db_side;

  rpcg_div_chain u_div_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid_q),
    .lanes_i (s4_lane_q),
    .side_i  (SIDE_W'(s4_side_q)),
    .valid_o (db_valid),
    .lanes_o (db_lanes),
    .side_o  (db_side_w)
  );

  assign db_side = side_b_t'(db_side_w);

  // output stage: sum blend terms, clamp, pick gray or zero
  logic signed [20:0] q3_s, mag, sv, v, mx21;
  logic [CHAN_W-1:0]  chan_d [3];
  logic [CHAN_W-1:0]  gray_v;

  always_comb begin
    mx21 = $signed({5'd0, max_level_q});
    q3_s = $signed({3'd0, db_lanes[3].num[17:0]});
    mag  = '0;
    sv   = '0;
    v    = '0;
    for (int i = 0; i < 3; i++) begin
      mag = $signed({3'd0, db_lanes[i].num[17:0]});
      sv  = db_side.sgn[i] ? -mag : mag;
      v   = db_side.lo ? sv : sv + q3_s;
      if (v < 21'sd0) begin
        chan_d[i] = '0;
      end else if (v > mx21) begin
        chan_d[i] = max_level_q;
      end else begin
        chan_d[i] = v[CHAN_W-1:0];
      end
    end
    gray_v = (db_lanes[0].num > DIV_W'(max_level_q)) ? max_level_q
                                                     : db_lanes[0].num[CHAN_W-1:0];
  end

  logic              out_valid_q;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= db_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    invalid_q <= db_side.bad;
    if (db_side.bad) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (db_side.gray) begin
      red_q   <= gray_v;
      green_q <= gray_v;
      blue_q  <= gray_v;
    end else begin
      red_q   <= chan_d[0];
      green_q <= chan_d[1];
      blue_q  <= chan_d[2];
    end
  end

  assign result_valid_o = out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign invalid_o      = invalid_q;

endmodule

FILE: hdl/rpcg_div_cell.sv
`timescale 1ns / 1ps
// one restoring division step for one lane, registered
// depends on rpcg_pkg

module rpcg_div_cell (
  input  logic               clk_i,
  input  rpcg_pkg::div_lane_t lane_i,
  output rpcg_pkg::div_lane_t lane_o
);
  import rpcg_pkg::*;

  logic [DEN_W:0] trial;
  logic           fits;
  div_lane_t      lane_d;
  div_lane_t      lane_q;

  always_comb begin
    trial      = {lane_i.rem, lane_i.num[DIV_W-1]};
    fits       = (trial >= {1'b0, lane_i.den});
    lane_d.den = lane_i.den;
    lane_d.num = {lane_i.num[DIV_W-2:0], fits};
    if (fits) begin
      lane_d.rem = DEN_W'(trial - {1'b0, lane_i.den});
    end else begin
      lane_d.rem = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

FILE: hdl/rpcg_div_chain.sv
`timescale 1ns / 1ps
// row of division cells, one quotient bit per cell, several lanes side by side
// depends on rpcg_pkg and rpcg_div_cell

module rpcg_div_chain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  rpcg_pkg::div_lane_t [rpcg_pkg::LANES-1:0] lanes_i,
  input  logic [rpcg_pkg::SIDE_W-1:0]           side_i,
  output logic                                  valid_o,
  output rpcg_pkg::div_lane_t [rpcg_pkg::LANES-1:0] lanes_o,
  output logic [rpcg_pkg::SIDE_W-1:0]           side_o
);
  import rpcg_pkg::*;

  div_lane_t        stage_w [LANES][DIV_W+1];
  logic [DIV_W-1:0] vld_q;
  logic [SIDE_W-1:0] side_q [DIV_W];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign stage_w[l][0] = lanes_i[l];
    for (genvar s = 0; s < DIV_W; s++) begin : g_step
      rpcg_div_cell u_cell (
        .clk_i  (clk_i),
        .lane_i (stage_w[l][s]),
        .lane_o (stage_w[l][s+1])
      );
    end
    assign lanes_o[l] = stage_w[l][DIV_W];
  end

  // valid and sideband travel alongside the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int i = 1; i < DIV_W; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = vld_q[DIV_W-1];
  assign side_o  = side_q[DIV_W-1];

endmodule

FILE: hdl/rpcg_checker.sv
`timescale 1ns / 1ps
// port-level checks of the rainbow palette color generator, bound to the top
// depends on rpcg_pkg

module rpcg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [rpcg_pkg::CHAN_W-1:0] red_o,
  input logic [rpcg_pkg::CHAN_W-1:0] green_o,
  input logic [rpcg_pkg::CHAN_W-1:0] blue_o,
  input logic                        invalid_o
);
  import rpcg_pkg::*;

  // flagged results carry no color
  a_invalid_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && invalid_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("invalid result with nonzero color");

  // every result comes from a request a fixed latency earlier
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, PIPE_LAT))
    else $error("result without matching request");

  // the block takes a request every clock
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind rainbow_palette_color_generator_core rpcg_checker u_rpcg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .red_o          (red_o),
  .green_o        (green_o),
  .blue_o         (blue_o),
  .invalid_o      (invalid_o)
);

FILE: tb/rainbow_palette_color_generator_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for rainbow_palette_color_generator_core
// depends on rpcg_pkg and the block's rtl; holds its own color predictor

module rainbow_palette_color_generator_core_test;
  import rpcg_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              invalid;
  } color_t;

  // expected colors in request order, plus the live register copy
  class color_board;
    color_t pending[$];
    int unsigned cols, rows, level, gray;
    int errors;

    function new();
      cols = 16; rows = 16; level = 255; gray = 0; errors = 0;
    endfunction

    function longint clip(longint v);
      if (v < 0) return 0;
      if (v > longint'(level)) return longint'(level);
      return v;
    endfunction

    // work out the palette color of one accepted request
    function void note_request(int unsigned xu, int unsigned yu);
      color_t c;
      longint w, n, m, half, g, v, x, y;
      longint hue[3];
      x = longint'(xu); y = longint'(yu);
      w = longint'(cols); m = longint'(level); n = longint'(rows) - longint'(gray);
      c = '0;
      if (w < 2 || w > MAX_COLUMNS || longint'(rows) > MAX_ROWS || n < 2 || x >= w ||
          y >= longint'(rows)) begin
        c.invalid = 1'b1;
      end else if (gray != 0 && y == n) begin
        // gray strip, rounded to nearest
        g = clip((2 * m * x + (w - 1)) / (2 * (w - 1)));
        c.red = CHAN_W'(g); c.green = CHAN_W'(g); c.blue = CHAN_W'(g);
      end else begin
        // six hue segments, edges at truncated multiples of w/6
        if (x < w / 6) begin
          hue[0] = m; hue[1] = m * 6 * x / w; hue[2] = 0;
        end else if (x < w * 2 / 6) begin
          hue[0] = m - m * (6 * x - w) / w; hue[1] = m; hue[2] = 0;
        end else if (x < w * 3 / 6) begin
          hue[0] = 0; hue[1] = m; hue[2] = m * (6 * x - 2 * w) / w;
        end else if (x < w * 4 / 6) begin
          hue[0] = 0; hue[1] = m - m * (6 * x - 3 * w) / w; hue[2] = m;
        end else if (x < w * 5 / 6) begin
          hue[0] = m * (6 * x - 4 * w) / w; hue[1] = 0; hue[2] = m;
        end else begin
          hue[0] = m; hue[1] = 0; hue[2] = m - m * (6 * x - 5 * w) / w;
        end
        // fade from black through full hue to white down the rows
        half = n / 2;
        for (int i = 0; i < 3; i++) begin
          if (y < half) v = hue[i] * y / half;
          else v = m * (y - (n - 1) / 2) / half + hue[i] * (n - 1 - y) / half;
          hue[i] = clip(v);
        end
        c.red = CHAN_W'(hue[0]); c.green = CHAN_W'(hue[1]); c.blue = CHAN_W'(hue[2]);
      end
      pending.push_back(c);
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        errors++;
      end
      if (got.invalid !== want.invalid) begin
        $display("%0t: invalid expected %0b actual %0b", $time, want.invalid, got.invalid);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [COL_W-1:0]  column_i = '0;
  logic [ROW_W-1:0]  row_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic              result_valid_o;
  logic [CHAN_W-1:0] red_o, green_o, blue_o;
  logic              invalid_o;

  color_board board = new();
  int idle_pct;

  always #5 clk_i = ~clk_i;

  rainbow_palette_color_generator_core dut (.*);

  // results are taken on the edge that ends their cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      board.check_color({red_o, green_o, blue_o, invalid_o});
    end
  end

  // issue one request; sender gaps drawn from idle_pct
  task automatic send_request(int unsigned x, int unsigned y);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    column_i <= COL_W'(x);
    row_i <= ROW_W'(y);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_request(x, y);
  endtask

  // drop start, let the pipe drain, then wait out the full latency
  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 10 * PIPE_LAT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GRID_COLUMNS: board.cols = val & 16'h1fff;
      CFG_GRID_ROWS:    board.rows = val & 16'h1fff;
      CFG_MAX_LEVEL:    board.level = val & 16'hffff;
      default:          board.gray = val & 1;
    endcase
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned m, int unsigned g);
    write_reg(CFG_GRID_COLUMNS, w);
    write_reg(CFG_GRID_ROWS, h);
    write_reg(CFG_MAX_LEVEL, m);
    write_reg(CFG_GRAY_STRIP, g);
  endtask

  // mostly in-grid positions, some at the far corner, some over the full range (often outside)
  task automatic random_requests(int count);
    int unsigned x, y;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9, 0))
        0: begin x = $urandom_range(4095, 0); y = $urandom_range(4095, 0); end
        1: begin x = board.cols - 1; y = board.rows - 1; end
        default: begin
          x = (board.cols == 0) ? 0 : $urandom_range(board.cols > 4096 ? 4095 : board.cols - 1, 0);
          y = (board.rows == 0) ? 0 : $urandom_range(board.rows > 4096 ? 4095 : board.rows - 1, 0);
        end
      endcase
      send_request(x & 12'hfff, y & 12'hfff);
    end
  endtask

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 45, 0, 29};
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting, corners, out-of-grid, segment edges, gray strip, bad settings, zero level
    send_request(0, 0);
    send_request(15, 15);
    send_request(16, 0);
    send_request(0, 16);
    send_request(4095, 4095);
    for (int x = 0; x < 16; x += 3) send_request(x, 8);
    drain();
    set_grid(4096, 4096, 65535, 1);
    send_request(4095, 4095);
    send_request(4095, 4094);
    send_request(2730, 2047);
    send_request(0, 4095);
    drain();
    set_grid(2, 3, 1, 1);
    send_request(1, 2);
    send_request(1, 1);
    send_request(0, 0);
    drain();
    set_grid(1, 16, 255, 0);
    send_request(0, 0);
    drain();
    set_grid(16, 2, 255, 1);
    send_request(3, 0);
    drain();
    set_grid(8191, 8191, 0, 0);
    send_request(5, 5);
    drain();
    set_grid(16, 16, 0, 0);
    send_request(5, 5);
    drain();

    // random phases across settings, extremes included
    for (int p = 0; p < 12; p++) begin
      idle_pct = phase_pct[p % 4];
      case (p % 6)
        0: set_grid(2, 2, 65535, 0);
        1: set_grid(4096, 4096, 65535, $urandom_range(1, 0));
        2: set_grid($urandom_range(4096, 2), $urandom_range(4096, 2), $urandom_range(65535, 1),
                    $urandom_range(1, 0));
        3: set_grid($urandom_range(40, 2), $urandom_range(40, 2), $urandom_range(65535, 1),
                    $urandom_range(1, 0));
        4: set_grid($urandom_range(8191, 0), $urandom_range(8191, 0), $urandom_range(65535, 0),
                    $urandom_range(1, 0));
        default: set_grid($urandom_range(300, 2), 3, $urandom_range(1000, 1), 1);
      endcase
      random_requests(125);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("rainbow_palette_color_generator_core_test: PASS");
    end else begin
      $display("rainbow_palette_color_generator_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("rainbow_palette_color_generator_core_test: FAIL");
    $finish;
  end

endmodule

FILE: rainbow_palette_color_generator_core.f
hdl/rpcg_pkg.sv
hdl/rpcg_div_cell.sv
hdl/rpcg_div_chain.sv
hdl/rainbow_palette_color_generator_core.sv
hdl/rpcg_checker.sv
tb/rainbow_palette_color_generator_core_test.sv
